FILE: hdl/svge_pkg.sv
// svge_pkg: shared types, codes and constants of the state vector gate engine.
// No dependencies; imported by every module in hdl/.
package svge_pkg;

   localparam int MAX_QUBITS = 10;
   localparam int ADDR_W     = MAX_QUBITS;
   localparam int DEPTH      = 1 << MAX_QUBITS;
   localparam int PAIR_W     = ADDR_W - 1;
   localparam int QUBIT_W    = 4;
   localparam int AMP_W      = 32;
   localparam int MIN_QUBITS = 3;

   localparam logic signed [AMP_W-1:0] INV_SQRT2_Q30 = 32'sd759250125;
   localparam logic signed [AMP_W-1:0] ONE_Q30       = 32'sh4000_0000;

   typedef enum logic [1:0] {
      CMD_INIT     = 2'd0,
      CMD_HADAMARD = 2'd1,
      CMD_TOFFOLI  = 2'd2,
      CMD_READ     = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_NUM_QUBITS  = 1'b0,
      CSR_START_STATE = 1'b1
   } csr_index_type;

   typedef struct packed {
      cmd_type              command;
      logic [QUBIT_W-1:0]   target_qubit;
      logic [QUBIT_W-1:0]   control_one;
      logic [QUBIT_W-1:0]   control_two;
      logic [9:0]           read_index;
   } req_type;

   typedef struct packed {
      logic signed [AMP_W-1:0] amplitude;
      logic                    status;
   } rsp_type;

   // store port controls
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [AMP_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } store_ctrl_type;

   // shared multiplier controls
   typedef struct packed {
      logic load_lo;
      logic load_hi;
   } alu_ctrl_type;

endpackage

FILE: hdl/svge_store.sv
// svge_store: amplitude memory, one write port and two registered read ports.
// Depends on svge_pkg.
module svge_store import svge_pkg::*; (
   input  logic             clock,
   input  store_ctrl_type   ctrl,
   output logic [AMP_W-1:0] rd_a,
   output logic [AMP_W-1:0] rd_b
);

   logic [AMP_W-1:0] store_mem [DEPTH];
   logic [AMP_W-1:0] rd_a_ff;
   logic [AMP_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         store_mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_a_ff <= store_mem[ctrl.rd_addr_a];
         rd_b_ff <= store_mem[ctrl.rd_addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

FILE: hdl/svge_alu.sv
// svge_alu: shared 1/sqrt(2) multiplier with floor, then saturating sum and difference.
// Depends on svge_pkg.
module svge_alu import svge_pkg::*; (
   input  logic                    clock,
   input  alu_ctrl_type            ctrl,
   input  logic signed [AMP_W-1:0] a_lo,
   input  logic signed [AMP_W-1:0] a_hi,
   output logic signed [AMP_W-1:0] sum_sat,
   output logic signed [AMP_W-1:0] diff_sat
);

   logic signed [AMP_W-1:0]   op;
   logic signed [2*AMP_W-2:0] prod;
   logic signed [AMP_W-1:0]   scaled;
   logic signed [AMP_W-1:0]   p0_ff;
   logic signed [AMP_W-1:0]   p1_ff;
   logic signed [AMP_W:0]     sum;
   logic signed [AMP_W:0]     diff;

   assign op     = ctrl.load_hi ? a_hi : a_lo;
   assign prod   = op * INV_SQRT2_Q30;
   // arithmetic shift by 30 is a floor; result fits 32 bits
   assign scaled = prod[AMP_W+29:30];

   always_ff @(posedge clock) begin
      if (ctrl.load_lo) begin
         p0_ff <= scaled;
      end
      if (ctrl.load_hi) begin
         p1_ff <= scaled;
      end
   end

   function automatic logic signed [AMP_W-1:0] sat(input logic signed [AMP_W:0] v);
      logic signed [AMP_W-1:0] r;
      if (v[AMP_W] != v[AMP_W-1]) begin
         r = v[AMP_W] ? {1'b1, {(AMP_W-1){1'b0}}} : {1'b0, {(AMP_W-1){1'b1}}};
      end else begin
         r = v[AMP_W-1:0];
      end
      return r;
   endfunction

   assign sum      = (AMP_W+1)'(p0_ff) + (AMP_W+1)'(p1_ff);
   assign diff     = (AMP_W+1)'(p0_ff) - (AMP_W+1)'(p1_ff);
   assign sum_sat  = sat(sum);
   assign diff_sat = sat(diff);

endmodule

FILE: hdl/state_vector_gate_engine.sv
// state_vector_gate_engine: top level, command sequencer around the amplitude store
// and the shared multiplier. Depends on svge_pkg, svge_store, svge_alu.
//
//   port group   dir  handshake              payload
//   req_*        in   req_valid/req_ready    req_data   (req_type)
//   rsp_*        out  rsp_valid/rsp_ready    rsp_data   (rsp_type)
//   csr_*        in   csr_valid/csr_ready    csr_index, csr_data
//
// Sequencing: a Hadamard pair takes a read, two multiplies and two writes on the
//   single write port. A Toffoli pair takes a read, plus two writes if it is swapped.
//   Init sweeps all 1024 entries. Read fetches the entry, then responds.
// Reset: a clearing pass writes zero to all 1024 entries with req_ready low;
//   csr writes are taken throughout.
// Stalls: req_ready is high only when the sequencer is idle; a finished beat
//   waits in the rsp register, so the next req beat can be taken meanwhile.
module state_vector_gate_engine import svge_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   // register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  csr_index_type csr_index,
   input  logic [9:0] csr_data
);

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_READ   = 9'b000000100,
      S_MUL0   = 9'b000001000,
      S_MUL1   = 9'b000010000,
      S_WRITE0 = 9'b000100000,
      S_WRITE1 = 9'b001000000,
      S_FETCH  = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ADDR_W-1:0]    tbit_ff, tbit_in;       // target bit of the index
   logic [ADDR_W-1:0]    cbits_ff, cbits_in;     // both control bits
   logic [ADDR_W-1:0]    lowmask_ff, lowmask_in; // index bits below the target
   logic [PAIR_W-1:0]    pair_ff, pair_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic                 init_clear_ff, init_clear_in;
   logic                 status_ff, status_in;
   logic [ADDR_W-1:0]    ridx_ff, ridx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [QUBIT_W-1:0]   num_qubits_ff;
   logic [9:0]           start_state_ff;

   logic [QUBIT_W-1:0]   n_eff;
   logic [ADDR_W-1:0]    idx_mask;
   logic [PAIR_W-1:0]    last_pair;
   logic [ADDR_W-1:0]    sidx;
   logic [ADDR_W-1:0]    idx_i;
   logic [ADDR_W-1:0]    idx_j;
   logic [ADDR_W-1:0]    pair_wide;
   logic                 last_now;
   logic                 ctl_set;
   logic                 hada_bad;
   logic                 toff_bad;
   logic [QUBIT_W-1:0]   pos_t;
   logic [QUBIT_W-1:0]   pos_1;
   logic [QUBIT_W-1:0]   pos_2;
   logic                 req_fire;

   store_ctrl_type       st_ctrl;
   alu_ctrl_type         alu_ctrl;
   logic [AMP_W-1:0]     rd_a;
   logic [AMP_W-1:0]     rd_b;
   logic signed [AMP_W-1:0] sum_sat;
   logic signed [AMP_W-1:0] diff_sat;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_qubits_ff  <= QUBIT_W'(MAX_QUBITS);
         start_state_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_QUBITS:  num_qubits_ff  <= csr_data[QUBIT_W-1:0];
            CSR_START_STATE: start_state_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp qubit count to the supported range
   always_comb begin
      if (num_qubits_ff < QUBIT_W'(MIN_QUBITS)) begin
         n_eff = QUBIT_W'(MIN_QUBITS);
      end else if (num_qubits_ff > QUBIT_W'(MAX_QUBITS)) begin
         n_eff = QUBIT_W'(MAX_QUBITS);
      end else begin
         n_eff = num_qubits_ff;
      end
   end

   assign idx_mask  = ADDR_W'(((ADDR_W+1)'(1) << n_eff) - (ADDR_W+1)'(1));
   assign last_pair = idx_mask[ADDR_W-1:1];
   assign sidx      = start_state_ff[ADDR_W-1:0] & idx_mask;

   // qubit q sits at index bit n-1-q
   assign pos_t = n_eff - QUBIT_W'(1) - req_data.target_qubit;
   assign pos_1 = n_eff - QUBIT_W'(1) - req_data.control_one;
   assign pos_2 = n_eff - QUBIT_W'(1) - req_data.control_two;

   assign hada_bad = (req_data.target_qubit >= n_eff);
   assign toff_bad = hada_bad
                   || (req_data.control_one >= n_eff)
                   || (req_data.control_two >= n_eff)
                   || (req_data.target_qubit == req_data.control_one)
                   || (req_data.target_qubit == req_data.control_two)
                   || (req_data.control_one == req_data.control_two);

   // pair index with a zero slipped in at the target bit
   assign pair_wide = {1'b0, pair_ff};
   assign idx_i     = ((pair_wide & ~lowmask_ff) << 1) | (pair_wide & lowmask_ff);
   assign idx_j     = idx_i | tbit_ff;
   assign last_now  = (pair_ff == last_pair);
   assign ctl_set   = ((idx_i & cbits_ff) == cbits_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      tbit_in       = tbit_ff;
      cbits_in      = cbits_ff;
      lowmask_in    = lowmask_ff;
      pair_in       = pair_ff;
      clr_in        = clr_ff;
      init_clear_in = init_clear_ff;
      status_in     = status_ff;
      ridx_in       = ridx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      st_ctrl           = '0;
      st_ctrl.rd_addr_a = idx_i;
      st_ctrl.rd_addr_b = idx_j;
      st_ctrl.wr_addr   = idx_i;
      alu_ctrl          = '0;

      unique case (state_ff)
         S_CLEAR: begin
            st_ctrl.wr_en   = 1'b1;
            st_ctrl.wr_addr = clr_ff;
            st_ctrl.wr_data = (init_clear_ff && (clr_ff == sidx)) ? ONE_Q30 : '0;
            clr_in          = clr_ff + ADDR_W'(1);
            if (&clr_ff) begin
               state_in = init_clear_ff ? S_FETCH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_data.command;
               tbit_in       = ADDR_W'(1) << pos_t;
               cbits_in      = (ADDR_W'(1) << pos_1) | (ADDR_W'(1) << pos_2);
               lowmask_in    = (ADDR_W'(1) << pos_t) - ADDR_W'(1);
               ridx_in       = req_data.read_index[ADDR_W-1:0] & idx_mask;
               pair_in       = '0;
               clr_in        = '0;
               init_clear_in = 1'b0;
               status_in     = 1'b0;
               unique case (req_data.command)
                  CMD_INIT: begin
                     init_clear_in = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  CMD_HADAMARD: begin
                     status_in = hada_bad;
                     state_in  = hada_bad ? S_FETCH : S_READ;
                  end
                  CMD_TOFFOLI: begin
                     status_in = toff_bad;
                     state_in  = toff_bad ? S_FETCH : S_READ;
                  end
                  CMD_READ: begin
                     state_in = S_FETCH;
                  end
                  default: state_in = S_FETCH;
               endcase
            end
         end
         S_READ: begin
            st_ctrl.rd_en = 1'b1;
            if (cmd_ff == CMD_HADAMARD) begin
               state_in = S_MUL0;
            end else if (ctl_set) begin
               state_in = S_WRITE0;
            end else if (last_now) begin
               state_in = S_FETCH;
            end else begin
               pair_in = pair_ff + PAIR_W'(1);
            end
         end
         S_MUL0: begin
            alu_ctrl.load_lo = 1'b1;
            state_in         = S_MUL1;
         end
         S_MUL1: begin
            alu_ctrl.load_hi = 1'b1;
            state_in         = S_WRITE0;
         end
         S_WRITE0: begin
            st_ctrl.wr_en   = 1'b1;
            st_ctrl.wr_addr = idx_i;
            st_ctrl.wr_data = (cmd_ff == CMD_HADAMARD) ? sum_sat : rd_b;
            state_in        = S_WRITE1;
         end
         S_WRITE1: begin
            st_ctrl.wr_en   = 1'b1;
            st_ctrl.wr_addr = idx_j;
            st_ctrl.wr_data = (cmd_ff == CMD_HADAMARD) ? diff_sat : rd_a;
            if (last_now) begin
               state_in = S_FETCH;
            end else begin
               pair_in  = pair_ff + PAIR_W'(1);
               state_in = S_READ;
            end
         end
         S_FETCH: begin
            st_ctrl.rd_en     = 1'b1;
            st_ctrl.rd_addr_a = (cmd_ff == CMD_READ) ? ridx_ff : sidx;
            state_in          = S_RESP;
         end
         S_RESP: begin
            // wait for the response register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.amplitude = rd_a;
               rsp_data_in.status    = status_ff;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         init_clear_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         init_clear_ff <= init_clear_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      tbit_ff     <= tbit_in;
      cbits_ff    <= cbits_in;
      lowmask_ff  <= lowmask_in;
      pair_ff     <= pair_in;
      status_ff   <= status_in;
      ridx_ff     <= ridx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------- datapath
   svge_store u_store (
      .clock (clock),
      .ctrl  (st_ctrl),
      .rd_a  (rd_a),
      .rd_b  (rd_b)
   );

   svge_alu u_alu (
      .clock    (clock),
      .ctrl     (alu_ctrl),
      .a_lo     (rd_a),
      .a_hi     (rd_b),
      .sum_sat  (sum_sat),
      .diff_sat (diff_sat)
   );

   // ------------------------------------------------------------ assertions
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !st_ctrl.wr_en)
      else $error("store written while idle");

   a_pair_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE0 || state_ff == S_WRITE1)
      |-> ((st_ctrl.wr_addr & ~idx_mask) == '0))
      else $error("gate write outside active vector");

   a_low_has_target_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ((idx_i & tbit_ff) == '0))
      else $error("pair low index has target bit set");

   a_rsp_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside response state");

endmodule
